FILE: hw/rtl/rgbhls_pkg.sv
`default_nettype none
package rgbhls_pkg;
    localparam int unsigned Q = 30;
    localparam logic [29:0] BASE_THIRD      = 30'd357913941;
    localparam logic [29:0] BASE_TWO_THIRDS = 30'd715827883;
    localparam logic [29:0] COEF0 = 30'd178949278;
    localparam logic [29:0] COEF1 = 30'd24165673;
    localparam logic [29:0] COEF2 = 30'd8460374;
    localparam logic [29:0] COEF3 = 30'd2133783;
endpackage
`default_nettype wire

FILE: hw/rtl/rgbhls_stream_if.sv
`default_nettype none
interface rgbhls_stream_if #(
    parameter int unsigned W = 24
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rgb_to_hls_cosine_hue_unit.sv
// The pipe is 70 register stages: channel ranking, divider setup, 32 restoring divider
// stages (x and saturation side by side), 31 square-root stages, four polynomial and
// multiply stages, then the output register. Throughput: one pixel per clock while the output is not stalled.
// Stall: hold the whole pipeline while the output register is full and unread.
// Reset: i_rst_n synchronous, active low, clears all valid bits; payload is not reset.
`default_nettype none
module rgb_to_hls_cosine_hue_unit #(
    parameter int unsigned CHANNEL_BITS  = 8,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rgbhls_stream_if.sink   i_pix,
    rgbhls_stream_if.source o_hls
);
    import rgbhls_pkg::*;

    localparam int unsigned C  = CHANNEL_BITS;
    localparam int unsigned F  = FRACTION_BITS;
    // Divider quotient bits: x needs 31 bits (0..2^30).
    localparam int unsigned XB = 31;
    // Saturation quotient: (2*d*FM + mx)/(2*mx) < 2^(F+1).
    localparam int unsigned SB = F + 1;
    localparam int unsigned SN = C + F + 2;  // numerator width
    localparam int unsigned ND = 32;         // divider stages (>= XB, SB)
    localparam int unsigned RS = 31;         // sqrt stages (61-bit radicand)
    localparam int unsigned NST = 2 + ND + RS + 4; // stages before the output register
    localparam logic [F-1:0] FM = '1;

    // Global stall: advance when the output stage is empty or taken.
    logic w_adv;
    assign w_adv = !o_hls.valid || o_hls.ready;
    assign i_pix.ready = w_adv;

    logic [C-1:0] w_r, w_g, w_b;
    assign w_r = i_pix.data[C-1:0];
    assign w_g = i_pix.data[2*C-1:C];
    assign w_b = i_pix.data[3*C-1:2*C];

    // ---------------- stage 0: rank channels ----------------
    logic [C-1:0] n_mx, n_md, n_mn;
    logic [29:0]  n_base;
    logic         n_neg;
    always_comb begin
        if (w_r > w_g) begin
            if (w_r > w_b) begin
                n_base = '0; n_mx = w_r;
                if (w_g > w_b) begin n_md = w_g; n_mn = w_b; n_neg = 1'b0; end
                else begin n_md = w_b; n_mn = w_g; n_neg = 1'b1; end
            end else begin
                n_base = BASE_TWO_THIRDS; n_mx = w_b; n_md = w_r; n_mn = w_g; n_neg = 1'b0;
            end
        end else begin
            if (w_g > w_b) begin
                n_base = BASE_THIRD; n_mx = w_g;
                if (w_r > w_b) begin n_md = w_r; n_mn = w_b; n_neg = 1'b1; end
                else begin n_md = w_b; n_mn = w_r; n_neg = 1'b0; end
            end else begin
                n_base = BASE_TWO_THIRDS; n_mx = w_b; n_md = w_g; n_mn = w_r; n_neg = 1'b1;
            end
        end
    end

    // One valid bit per stage, the last one for the output register.
    logic [NST:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[NST-1:0], i_pix.valid};
    end

    // Side-band carried down the whole pipe.
    logic [C-1:0]  r_mx  [NST];
    logic [29:0]   r_bs  [NST];
    logic          r_ng  [NST];
    logic          r_gr  [NST];

    // stage 0 registers
    logic [C-1:0] r_num0, r_den0;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx[0] <= n_mx; r_bs[0] <= n_base; r_ng[0] <= n_neg;
            r_gr[0] <= (w_r == w_g) && (w_g == w_b);
            r_num0  <= n_mx - n_md;
            r_den0  <= n_mx - n_mn;
        end
    end

    // ---------------- divider pipeline (restoring, one bit per stage) ------
    // x = (num<<30)/den ; sat = (2*d*FM + mx)/(2*mx)
    logic [XB+C-1:0] r_xrem [ND+1];
    logic [XB-1:0]   r_xq   [ND+1];
    logic [C-1:0]    r_xd   [ND+1];
    logic [SN-1:0]   r_srem [ND+1];
    logic [SB-1:0]   r_sq   [ND+1];
    logic [C:0]      r_sd   [ND+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx[1] <= r_mx[0]; r_bs[1] <= r_bs[0]; r_ng[1] <= r_ng[0]; r_gr[1] <= r_gr[0];
            r_xrem[0] <= {{(XB-30){1'b0}}, r_num0, 30'd0};
            r_xq[0]   <= '0;
            r_xd[0]   <= r_den0;
            r_srem[0] <= SN'(({{(F+2){1'b0}}, r_den0} * {{(C+2){1'b0}}, FM}) << 1)
                         + SN'(r_mx[0]);
            r_sq[0]   <= '0;
            r_sd[0]   <= {r_mx[0], 1'b0};
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        localparam int unsigned XS = (k < XB) ? (XB - 1 - k) : 0;
        localparam int unsigned SS = (k < SB) ? (SB - 1 - k) : 0;
        logic [XB+C-1:0] w_xt;
        logic [SN-1:0]   w_st;
        logic            w_xok, w_sok;
        assign w_xt  = (XB+C)'(r_xd[k]) << XS;
        assign w_st  = SN'(r_sd[k]) << SS;
        assign w_xok = (k < XB) && (r_xd[k] != '0) && (r_xrem[k] >= w_xt)
                       && ((w_xt >> XS) == (XB+C)'(r_xd[k]));
        assign w_sok = (k < SB) && (r_sd[k] != '0) && (r_srem[k] >= w_st)
                       && ((w_st >> SS) == SN'(r_sd[k]));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mx[k+2] <= r_mx[k+1]; r_bs[k+2] <= r_bs[k+1];
                r_ng[k+2] <= r_ng[k+1]; r_gr[k+2] <= r_gr[k+1];
                r_xd[k+1] <= r_xd[k]; r_sd[k+1] <= r_sd[k];
                r_xrem[k+1] <= w_xok ? r_xrem[k] - w_xt : r_xrem[k];
                r_srem[k+1] <= w_sok ? r_srem[k] - w_st : r_srem[k];
                r_xq[k+1]   <= w_xok ? (r_xq[k] | (XB'(1) << XS)) : r_xq[k];
                r_sq[k+1]   <= w_sok ? (r_sq[k] | (SB'(1) << SS)) : r_sq[k];
            end
        end
    end

    // ---------------- sqrt pipeline (two radicand bits per stage) ----------
    localparam int unsigned P0 = ND + 2; // side-band index entering sqrt
    logic [61:0]  w_rv0;
    logic [30:0]  w_x0;
    logic [F-1:0] w_sat0;
    assign w_rv0  = {1'b0, (61'(31'h4000_0000) - 61'(r_xq[ND])) << 30};
    assign w_x0   = r_xq[ND];
    assign w_sat0 = (r_sd[ND] == '0) ? '0 : r_sq[ND][F-1:0];
    logic [61:0] r_rvq [RS];
    logic [61:0] r_rrq [RS];
    logic [30:0] r_xqq [RS];
    logic [F-1:0] r_stq [RS];
    for (genvar k = 0; k < RS; k++) begin : g_sqrt
        localparam int unsigned BP = 2 * (RS - 1 - k);
        logic [61:0] w_v, w_res, w_bit, w_t;
        assign w_v   = (k == 0) ? w_rv0 : r_rvq[(k == 0) ? 0 : k-1];
        assign w_res = (k == 0) ? '0 : r_rrq[(k == 0) ? 0 : k-1];
        assign w_bit = 62'(1) << BP;
        assign w_t   = w_res + w_bit;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mx[P0+k] <= r_mx[P0+k-1]; r_bs[P0+k] <= r_bs[P0+k-1];
                r_ng[P0+k] <= r_ng[P0+k-1]; r_gr[P0+k] <= r_gr[P0+k-1];
                r_xqq[k] <= (k == 0) ? w_x0 : r_xqq[(k == 0) ? 0 : k-1];
                r_stq[k] <= (k == 0) ? w_sat0 : r_stq[(k == 0) ? 0 : k-1];
                if (w_v >= w_t) begin
                    r_rvq[k] <= w_v - w_t;
                    r_rrq[k] <= (w_res >> 1) + w_bit;
                end else begin
                    r_rvq[k] <= w_v;
                    r_rrq[k] <= w_res >> 1;
                end
            end
        end
    end

    // ---------------- polynomial and hue (4 stages) ----------------
    localparam int unsigned P1 = P0 + RS;
    logic [30:0] r_sqv;
    logic [29:0] r_p3, r_p2, r_p1;
    logic [30:0] r_xa, r_xb;
    logic [30:0] r_sqa, r_sqb, r_sqc;
    logic [F-1:0] r_sa, r_sb, r_sc, r_sd2;
    logic [61:0] w_m3, w_m2, w_m1;
    logic [60:0] w_ma;
    assign w_m3  = 62'(COEF3) * 62'(r_xqq[RS-1]);
    assign r_sqv = r_rrq[RS-1][30:0];
    assign w_m2  = 62'(r_p3) * 62'(r_xa);
    assign w_m1  = 62'(r_p2) * 62'(r_xb);
    assign w_ma  = 61'(r_sqc) * 61'(r_p1);
    logic [29:0] r_a;

    for (genvar j = P1; j < NST; j++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mx[j] <= r_mx[j-1]; r_bs[j] <= r_bs[j-1];
                r_ng[j] <= r_ng[j-1]; r_gr[j] <= r_gr[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p3 <= COEF2 - w_m3[59:30];
            r_xa <= r_xqq[RS-1]; r_sqa <= r_sqv; r_sa <= r_stq[RS-1];
            r_p2 <= COEF1 - w_m2[59:30];
            r_xb <= r_xa; r_sqb <= r_sqa; r_sb <= r_sa;
            r_p1 <= COEF0 - w_m1[59:30];
            r_sqc <= r_sqb; r_sc <= r_sb;
            r_a  <= w_ma[59:30];
            r_sd2 <= r_sc;
        end
    end

    logic [29:0] w_h;
    logic [30:0] w_hr;
    assign w_h  = r_ng[NST-1] ? (r_bs[NST-1] - r_a) : (r_bs[NST-1] + r_a);
    assign w_hr = 31'(w_h) + (31'(1) << (29 - F));

    logic [F-1:0] r_hue, r_st;
    logic [C-1:0] r_lt;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue <= r_gr[NST-1] ? '0 : w_hr[29:30-F];
            r_lt  <= r_mx[NST-1];
            r_st  <= r_sd2;
        end
    end

    assign o_hls.valid = r_vld[NST];
    assign o_hls.data  = {r_st, r_lt, r_hue};

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_hls.valid && !o_hls.ready) |=> $stable(o_hls.data);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hls.ready |-> i_pix.ready) else $error("input stalled with free output");
    a_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hls.valid && o_hls.data[F+C-1:F] == '0) |-> o_hls.data[2*F+C-1:F+C] == '0)
        else $error("black pixel saturation nonzero");
endmodule
`default_nettype wire

FILE: bench/rgb_to_hls_cosine_hue_unit_tb.sv
`timescale 1ns / 1ps
module rgb_to_hls_cosine_hue_unit_tb;
    import rgbhls_pkg::*;

    localparam int unsigned N_DIRECTED = 12;
    localparam int unsigned N_RANDOM   = 1100;
    localparam int unsigned N_TOTAL    = N_DIRECTED + N_RANDOM;
    localparam int unsigned LATENCY    = 69;
    localparam int unsigned CYCLE_CAP  = 400000;

    // Red sits in the low byte of the transaction.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Hue sits in the low bits of the result.
    typedef struct packed {
        logic [15:0] saturation;
        logic [7:0]  lightness;
        logic [15:0] hue;
    } hls_t;

    // One directed row: a pixel, plus a typed-in result where it is obvious.
    typedef struct {
        pixel_t pix;
        bit     known;
        hls_t   res;
    } pixel_row_t;

    logic i_clk;
    logic i_rst_n;

    rgbhls_stream_if #(.W(24)) pix_if ();
    rgbhls_stream_if #(.W(40)) hls_if ();

    rgb_to_hls_cosine_hue_unit #(
        .CHANNEL_BITS (8),
        .FRACTION_BITS(16)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if.sink),
        .o_hls  (hls_if.source)
    );

    pixel_row_t  directed_rows[N_DIRECTED];
    hls_t        pending_hls[$];
    int unsigned n_errors;
    int unsigned n_sent;
    int unsigned cycle_count;
    int unsigned hold_cycles;
    bit          pressure_done;

    function automatic pixel_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    function automatic hls_t mk_hls(logic [15:0] h, logic [7:0] l, logic [15:0] s);
        hls_t res;
        res.hue        = h;
        res.lightness  = l;
        res.saturation = s;
        return res;
    endfunction

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // acos(num/den)/(3*pi) in Q30 from the polynomial fit.
    function automatic longint unsigned acos_turns_q30(longint unsigned num,
                                                       longint unsigned den);
        longint unsigned x;
        longint unsigned sq;
        longint unsigned p;
        longint unsigned one;
        one = 64'd1 << Q;
        if (den == 0) return 0;
        if (num > den) num = den;
        x  = (num << Q) / den;
        sq = int_sqrt((one - x) << Q);
        p  = 64'(COEF2) - ((64'(COEF3) * x) >> Q);
        p  = 64'(COEF1) - ((p * x) >> Q);
        p  = 64'(COEF0) - ((p * x) >> Q);
        return (sq * p) >> Q;
    endfunction

    // Predict the hue/lightness/saturation of one pixel.
    function automatic hls_t convert_pixel(pixel_t px);
        longint unsigned r, g, b, mx, md, mn, base, h, a, one, sat, hue;
        bit neg;
        hls_t res;
        r   = px.red;
        g   = px.green;
        b   = px.blue;
        one = 64'd1 << Q;
        if (r > g) begin
            if (r > b) begin
                base = 0; mx = r;
                if (g > b) begin md = g; mn = b; neg = 0; end
                else begin md = b; mn = g; neg = 1; end
            end else begin
                base = BASE_TWO_THIRDS; mx = b; md = r; mn = g; neg = 0;
            end
        end else begin
            if (g > b) begin
                base = BASE_THIRD; mx = g;
                if (r > b) begin md = r; mn = b; neg = 1; end
                else begin md = b; mn = r; neg = 0; end
            end else begin
                base = BASE_TWO_THIRDS; mx = b; md = g; mn = r; neg = 1;
            end
        end
        if (mx == 0) sat = 0;
        else sat = ((mx - mn) * 65535 * 2 + mx) / (2 * mx);
        if (r == g && g == b) begin
            hue = 0;
        end else begin
            a = acos_turns_q30(mx - md, mx - mn);
            if (neg) h = (base + one - a) & (one - 1);
            else h = (base + a) & (one - 1);
            hue = ((h + (64'd1 << 13)) >> 14) & 64'hFFFF;
        end
        res.hue        = hue[15:0];
        res.lightness  = mx[7:0];
        res.saturation = sat[15:0];
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d (time %0t)", field, got, want, $time);
    endtask

    // Pick a random pixel: half uniform, some with two channels tied, some near-grey, some dark.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        px   = pixel_t'(24'($urandom));
        if (kind == 0) begin
            px.green = px.red;               // two channels tied
        end else if (kind == 1) begin
            px.blue = px.green;
        end else if (kind == 2) begin
            px.blue = px.red;
        end else if (kind == 3) begin
            px.red   = 8'($urandom_range(0, 3));   // very dark
            px.green = 8'($urandom_range(0, 3));
            px.blue  = 8'($urandom_range(0, 3));
        end else if (kind == 4) begin
            px.green = px.red + 8'($urandom_range(0, 2));  // almost grey
            px.blue  = px.red - 8'($urandom_range(0, 2));
        end
        return px;
    endfunction

    function automatic pixel_t pixel_for(int unsigned idx);
        if (idx < N_DIRECTED) return directed_rows[idx].pix;
        return random_pixel();
    endfunction

    // Idle percentage for each side; phase follows the number of items sent.
    function automatic int unsigned sender_idle_pct();
        if (n_sent < N_TOTAL / 3) return 18;
        if (n_sent < 2 * N_TOTAL / 3) return 81;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (n_sent < N_TOTAL / 3) return 81;
        if (n_sent < 2 * N_TOTAL / 3) return 18;
        return 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Directed rows: extremes, each primary, five of the six hue sectors, grey and black.
    initial begin
        directed_rows[0]  = '{mk_pixel(8'd0,   8'd0,   8'd0),   1'b1,
                              mk_hls(16'd0, 8'd0, 16'd0)};
        directed_rows[1]  = '{mk_pixel(8'd255, 8'd255, 8'd255), 1'b1,
                              mk_hls(16'd0, 8'd255, 16'd0)};
        directed_rows[2]  = '{mk_pixel(8'd128, 8'd128, 8'd128), 1'b1,
                              mk_hls(16'd0, 8'd128, 16'd0)};
        directed_rows[3]  = '{mk_pixel(8'd255, 8'd0,   8'd0),   1'b1,
                              mk_hls(16'd0, 8'd255, 16'd65535)};
        directed_rows[4]  = '{mk_pixel(8'd0,   8'd255, 8'd0),   1'b1,
                              mk_hls(16'd21845, 8'd255, 16'd65535)};
        directed_rows[5]  = '{mk_pixel(8'd0,   8'd0,   8'd255), 1'b1,
                              mk_hls(16'd43691, 8'd255, 16'd65535)};
        directed_rows[6]  = '{mk_pixel(8'd200, 8'd100, 8'd50),  1'b0, '0};
        directed_rows[7]  = '{mk_pixel(8'd200, 8'd50,  8'd100), 1'b0, '0};
        directed_rows[8]  = '{mk_pixel(8'd100, 8'd200, 8'd50),  1'b0, '0};
        directed_rows[9]  = '{mk_pixel(8'd50,  8'd200, 8'd100), 1'b0, '0};
        directed_rows[10] = '{mk_pixel(8'd100, 8'd50,  8'd200), 1'b0, '0};
        directed_rows[11] = '{mk_pixel(8'd1,   8'd0,   8'd1),   1'b0, '0};
    end

    // Reset, then feed pixels; record the expected result at each accepted transaction.
    initial begin
        pixel_t cur;
        hls_t   want;
        n_sent       = 0;
        n_errors     = 0;
        i_rst_n      <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur = '0;
        while (n_sent < N_TOTAL || pix_if.valid) begin
            @(posedge i_clk);
            if (pix_if.valid && pix_if.ready) begin
                want = convert_pixel(cur);
                if (n_sent < N_DIRECTED && directed_rows[n_sent].known
                        && want != directed_rows[n_sent].res) begin
                    report_mismatch("directed row", n_sent, 0);
                end
                pending_hls.push_back(want);
                n_sent++;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (n_sent < N_TOTAL && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    cur = pixel_for(n_sent);
                    pix_if.valid <= 1'b1;
                    pix_if.data  <= cur;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
        // Drain, then let the pipeline settle before the verdict.
        while (pending_hls.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS rgb_to_hls_cosine_hue_unit");
        end else begin
            $display("FAIL rgb_to_hls_cosine_hue_unit");
        end
        $finish;
    end

    // Receiver: random stalls per phase, and one long hold-off at the start
    // of the last phase so the pipeline fills and backs up the input.
    initial begin
        hls_if.ready  <= 1'b0;
        hold_cycles   = 0;
        pressure_done = 0;
        forever begin
            @(posedge i_clk);
            if (!pressure_done && n_sent >= 2 * N_TOTAL / 3) begin
                pressure_done = 1;
                hold_cycles   = 400;
            end
            if (hold_cycles != 0) begin
                hold_cycles--;
                hls_if.ready <= 1'b0;
            end else begin
                hls_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        hls_t got;
        hls_t want;
        if (i_rst_n && hls_if.valid && hls_if.ready) begin
            got = hls_if.data;
            if (pending_hls.size() == 0) begin
                report_mismatch("unexpected result", 32'(got.hue), 0);
            end else begin
                want = pending_hls.pop_front();
                if (got.hue != want.hue)
                    report_mismatch("hue", 32'(got.hue), 32'(want.hue));
                if (got.lightness != want.lightness)
                    report_mismatch("lightness", 32'(got.lightness), 32'(want.lightness));
                if (got.saturation != want.saturation)
                    report_mismatch("saturation", 32'(got.saturation),
                                    32'(want.saturation));
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL rgb_to_hls_cosine_hue_unit");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/rgbhls_pkg.sv
hw/rtl/rgbhls_stream_if.sv
hw/rtl/rgb_to_hls_cosine_hue_unit.sv
bench/rgb_to_hls_cosine_hue_unit_tb.sv
